// ===== rtl/dkms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkms_pkg
// Shared constants, codes and helpers for the k-mer mismatch scanner.
// ----------------------------------------------------------------------------
package dkms_pkg;

    // nucleotide characters
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;

    // 2-bit symbol codes
    typedef logic [1:0] t_sym;
    localparam t_sym SYM_OTHER = 2'd0;
    localparam t_sym SYM_T     = 2'd1;
    localparam t_sym SYM_C     = 2'd2;
    localparam t_sym SYM_G     = 2'd3;

    // configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx REG_MOTIF_CODE     = 1'd0;
    localparam t_cfg_idx REG_MISMATCH_LIMIT = 1'd1;

    // field widths
    localparam int MOTIF_W  = 30;
    localparam int LIMIT_W  = 4;
    localparam int DIST_W   = 4;
    localparam int START_W  = 11;
    localparam int SMIN_W   = 5;
    localparam int OUT_W    = 40;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

    // character to symbol code
    function automatic t_sym code_of(input logic [7:0] ch);
        t_sym c;
        case (ch)
            CHAR_T:  c = SYM_T;
            CHAR_C:  c = SYM_C;
            CHAR_G:  c = SYM_G;
            default: c = SYM_OTHER;
        endcase
        return c;
    endfunction

    // one symbol position differs
    function automatic logic sym_differs(input t_sym a, input t_sym b);
        return |(a ^ b);
    endfunction

endpackage

// ===== rtl/dkms_mismatch_count.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkms_mismatch_count
// Counts differing 2-bit symbols between a window and the motif.
// ----------------------------------------------------------------------------
module dkms_mismatch_count
    import dkms_pkg::*;
#(
    parameter int MOTIF_LEN = 15,
    parameter int CNT_W     = 5
) (
    input  logic [2*MOTIF_LEN-1:0] i_window,
    input  logic [2*MOTIF_LEN-1:0] i_motif,
    output logic [CNT_W-1:0]       o_count
);

    localparam int NG = (MOTIF_LEN + 7) / 8;

    logic [MOTIF_LEN-1:0] diff;
    logic [3:0]           grp [NG];

    // per-symbol mismatch flags
    always_comb begin
        for (int i = 0; i < MOTIF_LEN; i++) begin
            diff[i] = sym_differs(i_window[2*i +: 2], i_motif[2*i +: 2]);
        end
    end

    // groups of eight symbols counted in parallel
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            grp[g] = 4'd0;
            for (int j = 0; j < 8; j++) begin
                if (g * 8 + j < MOTIF_LEN) begin
                    grp[g] = grp[g] + 4'(diff[g * 8 + j]);
                end
            end
        end
    end

    // sum of group counts
    always_comb begin
        o_count = '0;
        for (int g = 0; g < NG; g++) begin
            o_count = o_count + CNT_W'(grp[g]);
        end
    end

endmodule

// ===== rtl/dna_kmer_mismatch_scanner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_kmer_mismatch_scanner_unit
// Sliding-window Hamming matcher of 2-bit coded DNA against a set motif.
// ----------------------------------------------------------------------------
// One nucleotide byte enters per transaction and one result leaves per
// transaction; the block sustains one symbol per clock while results are
// taken, through an input register, then the window update, mismatch count and
// minimum tracking in one combinational pass into the result register. Input ready
// drops only when both stages hold data and the result is not taken. The
// sequence summary fields are valid on the result that carries tlast, after
// which the window, position counter and minimum are cleared. Configuration
// writes take effect at once and are meant to be issued while idle.
// ----------------------------------------------------------------------------
module dna_kmer_mismatch_scanner_unit
    import dkms_pkg::*;
#(
    parameter int MOTIF_LEN   = 15,
    parameter int MAX_SEQ_LEN = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  t_cfg_idx             i_cfg_idx,
    input  logic [MOTIF_W-1:0]   i_cfg_data,
    // symbol stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,  // [7:0] symbol_byte
    input  logic                 i_s_tlast,  // last_in_sequence
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [0] window_full, [4:1] window_distance, [5] window_hit,
    // [16:6] window_start, [21:17] sequence_min, [22] sequence_hit,
    // [33:23] best_start, [39:34] zero
    output logic [OUT_W-1:0]     o_m_tdata,
    output logic                 o_m_tlast   // sequence_done
);

    localparam int WIN_W   = 2 * MOTIF_LEN;
    localparam int CNT_TOP = (MAX_SEQ_LEN > MOTIF_LEN) ? MAX_SEQ_LEN : MOTIF_LEN;
    localparam int CNT_W   = $clog2(CNT_TOP + 1);
    localparam int MIN_W   = $clog2(MOTIF_LEN + 2);
    localparam int CMP_W   = (MIN_W > LIMIT_W) ? MIN_W : LIMIT_W;

    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_SEQ_LEN);
    localparam logic [CNT_W-1:0] LEN_CNT  = CNT_W'(MOTIF_LEN);
    localparam logic [CNT_W-1:0] LEN_M1   = CNT_W'(MOTIF_LEN - 1);
    localparam logic [MIN_W-1:0] NO_MIN   = MIN_W'(MOTIF_LEN + 1);
    localparam logic [CMP_W-1:0] LEN_CMP  = CMP_W'(MOTIF_LEN);

    // configuration registers
    logic [MOTIF_W-1:0] r_motif;
    logic [LIMIT_W-1:0] r_limit;

    // pipeline registers
    logic               r_in_valid;
    t_sym               r_in_code;
    logic               r_in_last;
    logic               r_res_valid;
    logic [OUT_W-1:0]   r_res_data;
    logic               r_res_last;

    // per-sequence state
    logic [WIN_W-1:0]   r_win,  n_win;
    logic [CNT_W-1:0]   r_seen, n_seen;
    logic [MIN_W-1:0]   r_min,  n_min;
    logic [CNT_W-1:0]   r_best, n_best;

    logic               res_free;
    logic               advance;
    logic [WIN_W-1:0]   win_next;
    logic [CNT_W-1:0]   seen_next;
    logic               full;
    logic [MIN_W-1:0]   dist_raw;
    logic [MIN_W-1:0]   win_dist;
    logic [CNT_W-1:0]   start;
    logic               hit;
    logic               better;
    logic [MIN_W-1:0]   cand_min;
    logic [CNT_W-1:0]   cand_best;
    logic               seq_hit;
    logic [OUT_W-1:0]   res_data;

    // handshake
    assign res_free   = !r_res_valid || i_m_tready;
    assign advance    = r_in_valid && res_free;
    assign o_s_tready = !r_in_valid || res_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motif <= '0;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MOTIF_CODE:     r_motif <= i_cfg_data;
                REG_MISMATCH_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                default:            r_motif <= r_motif;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_code <= code_of(i_s_tdata);
            r_in_last <= i_s_tlast;
        end
    end

    // window shift and saturating position count
    assign win_next  = {r_win[WIN_W-3:0], r_in_code};
    assign seen_next = (r_seen < MAX_CNT) ? r_seen + 1'b1 : r_seen;
    assign full      = seen_next >= LEN_CNT;

    dkms_mismatch_count #(
        .MOTIF_LEN (MOTIF_LEN),
        .CNT_W     (MIN_W)
    ) u_count (
        .i_window (win_next),
        .i_motif  (WIN_W'(r_motif)),
        .o_count  (dist_raw)
    );

    // window result and running minimum
    always_comb begin
        win_dist  = full ? dist_raw : '0;
        start     = full ? seen_next - LEN_M1 : '0;
        hit       = full && (CMP_W'(dist_raw) <= CMP_W'(r_limit));
        better    = full && (dist_raw < r_min);
        cand_min  = better ? dist_raw : r_min;
        cand_best = better ? start : r_best;
        seq_hit   = (CMP_W'(cand_min) <= LEN_CMP) && (CMP_W'(cand_min) <= CMP_W'(r_limit));
    end

    // result packing
    always_comb begin
        res_data        = '0;
        res_data[0]     = full;
        res_data[4:1]   = DIST_W'(win_dist);
        res_data[5]     = hit;
        res_data[16:6]  = START_W'(start);
        if (r_in_last) begin
            res_data[21:17] = SMIN_W'(cand_min);
            res_data[22]    = seq_hit;
            res_data[33:23] = START_W'(cand_best);
        end
    end

    // next sequence state
    always_comb begin
        n_win  = r_win;
        n_seen = r_seen;
        n_min  = r_min;
        n_best = r_best;
        if (advance) begin
            if (r_in_last) begin
                n_win  = '0;
                n_seen = '0;
                n_min  = NO_MIN;
                n_best = '0;
            end else begin
                n_win  = win_next;
                n_seen = seen_next;
                n_min  = cand_min;
                n_best = cand_best;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_seen <= '0;
            r_min  <= NO_MIN;
            r_best <= '0;
        end else begin
            r_win  <= n_win;
            r_seen <= n_seen;
            r_min  <= n_min;
            r_best <= n_best;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_free) begin
            r_res_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res_data <= res_data;
            r_res_last <= r_in_last;
        end
    end

    assign o_m_tvalid = r_res_valid;
    assign o_m_tdata  = r_res_data;
    assign o_m_tlast  = r_res_last;

    // checks
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_seen == '0 && r_win == '0)
        else $error("sequence state not cleared after last symbol");

    a_seen_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= MAX_CNT)
        else $error("position count beyond maximum length");

    a_min_best_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_min == NO_MIN) == (r_best == '0))
        else $error("best start disagrees with running minimum");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_in_valid && r_res_valid && !i_m_tready)
        else $error("input stalled with room in the pipeline");

endmodule

// ===== bench/tb_dna_kmer_mismatch_scanner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dna_kmer_mismatch_scanner_unit
// Self-checking bench for the sliding-window k-mer mismatch scanner.
// ----------------------------------------------------------------------------
// Nucleotide bytes are streamed in as runs marked by tlast. Each accepted
// transaction is run through a local scanner model that keeps its own window,
// position counter and running minimum. The predicted result is queued and
// every result transaction is compared field by field with the oldest entry.
// Phases cover directed corner cases, random runs with planted motifs under
// several motif and limit settings, sender gaps and receiver stalls, a long
// result hold-off that backs up the input, and a run long enough to saturate
// the position counter.
// ----------------------------------------------------------------------------
module tb_dna_kmer_mismatch_scanner_unit;
    import dkms_pkg::*;

    localparam int WIN_LEN    = 15;
    localparam int SEQ_CAP    = 1024;
    localparam int NO_MIN     = WIN_LEN + 1;
    localparam int SAT_START  = SEQ_CAP - WIN_LEN + 1;
    localparam int IDLE_LIMIT = 5000;
    localparam int SHOW_MAX   = 10;
    localparam logic [7:0] CHAR_A = 8'h41;

    typedef struct packed {
        logic                full;
        logic [DIST_W-1:0]   distance;
        logic                hit;
        logic [START_W-1:0]  start;
        logic                done;
        logic [SMIN_W-1:0]   smin;
        logic                seq_hit;
        logic [START_W-1:0]  best;
    } t_scan_result;

    // dut signals
    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_cfg_we   = 1'b0;
    t_cfg_idx           i_cfg_idx  = REG_MOTIF_CODE;
    logic [MOTIF_W-1:0] i_cfg_data = '0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [7:0]         i_s_tdata  = '0;
    logic               i_s_tlast  = 1'b0;
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [OUT_W-1:0]   o_m_tdata;
    logic               o_m_tlast;

    // scanner model state and configuration
    logic [MOTIF_W-1:0]  mdl_motif;
    logic [LIMIT_W-1:0]  mdl_limit;
    logic [MOTIF_W-1:0]  mdl_window;
    logic [START_W-1:0]  mdl_seen;
    logic [SMIN_W-1:0]   mdl_run_min;
    logic [START_W-1:0]  mdl_run_best;

    t_scan_result expected_results[$];

    // traffic shaping
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    // bookkeeping
    int mismatch_count = 0;
    int idle_cycles    = 0;
    int n_symbols      = 0;
    int n_results      = 0;
    int n_sequences    = 0;
    int n_window_hits  = 0;
    int n_seq_hits     = 0;
    int n_saturated    = 0;
    int n_in_stalls    = 0;

    dna_kmer_mismatch_scanner_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [7:0] symbol_byte
        .i_s_tlast  (i_s_tlast),   // last_in_sequence
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [0] full, [4:1] distance, [5] hit, [16:6] start,
                                   // [21:17] seq min, [22] seq hit, [33:23] best
        .o_m_tlast  (o_m_tlast)    // sequence_done
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // scanner model
    // ------------------------------------------------------------------------

    function automatic logic [1:0] symbol_code(input logic [7:0] ch);
        if (ch == CHAR_T) return SYM_T;
        else if (ch == CHAR_C) return SYM_C;
        else if (ch == CHAR_G) return SYM_G;
        return SYM_OTHER;
    endfunction

    task automatic clear_run_state();
        mdl_window   = '0;
        mdl_seen     = '0;
        mdl_run_min  = SMIN_W'(NO_MIN);
        mdl_run_best = '0;
    endtask

    // shift one symbol in and form the result it causes
    task automatic predict_scan(input logic [7:0] ch, input logic last,
                                output t_scan_result r);
        logic [MOTIF_W-1:0] diff;
        int unsigned        n_mism;
        r          = '0;
        mdl_window = {mdl_window[MOTIF_W-3:0], symbol_code(ch)};
        if (mdl_seen < SEQ_CAP)
            mdl_seen = mdl_seen + 1'b1;
        if (mdl_seen >= WIN_LEN) begin
            diff   = mdl_window ^ mdl_motif;
            n_mism = 0;
            for (int k = 0; k < WIN_LEN; k++)
                if (diff[2*k +: 2] != 2'b00)
                    n_mism++;
            r.full     = 1'b1;
            r.distance = DIST_W'(n_mism);
            r.start    = mdl_seen - START_W'(WIN_LEN - 1);
            r.hit      = (n_mism <= mdl_limit);
            // ties keep the earlier start
            if (n_mism < mdl_run_min) begin
                mdl_run_min  = SMIN_W'(n_mism);
                mdl_run_best = r.start;
            end
        end
        r.done = last;
        if (last) begin
            r.smin    = mdl_run_min;
            r.seq_hit = (mdl_run_min <= WIN_LEN) && (mdl_run_min <= mdl_limit);
            r.best    = mdl_run_best;
            clear_run_state();
        end
    endtask

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one symbol transaction, predicted once accepted
    task automatic send_symbol(input logic [7:0] ch, input logic last);
        t_scan_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        predict_scan(ch, last, r);
        expected_results = {expected_results, r};
        n_symbols++;
        if (last)
            n_sequences++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    // wait until every expected result is in
    task automatic drain();
        release_input();
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [MOTIF_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == REG_MOTIF_CODE)
            mdl_motif = value;
        else
            mdl_limit = value[LIMIT_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // a byte carrying the given code; code zero picks any byte other than T, C or G
    function automatic logic [7:0] byte_for_code(input logic [1:0] code);
        logic [7:0] ch;
        case (code)
            SYM_T:   ch = CHAR_T;
            SYM_C:   ch = CHAR_C;
            SYM_G:   ch = CHAR_G;
            default: begin
                ch = 8'($urandom_range(255));
                if (ch == CHAR_T || ch == CHAR_C || ch == CHAR_G)
                    ch = CHAR_A;
            end
        endcase
        return ch;
    endfunction

    // one run; planted runs follow the motif from a random phase with mutations
    task automatic send_sequence(input int len, input bit plant, input int mut_pct);
        int         phase;
        int         k;
        logic [1:0] code;
        phase = $urandom_range(WIN_LEN - 1);
        for (int i = 0; i < len; i++) begin
            k = (i + phase) % WIN_LEN;
            if (plant && $urandom_range(99) >= mut_pct)
                code = mdl_motif[MOTIF_W-1-2*k -: 2];
            else
                code = 2'($urandom_range(3));
            send_symbol(byte_for_code(code), i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // result receiver, hold-off and checker
    // ------------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_MAX)
                $display("mismatch on result %0d: %s expected %0d, got %0d",
                         n_results, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_scan_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOW_MAX)
                    $display("result %0d arrived with nothing expected, data %h",
                             n_results, o_m_tdata);
            end else begin
                want = expected_results.pop_front();
                check_field("window_full",     want.full,     o_m_tdata[0]);
                check_field("window_distance", want.distance, o_m_tdata[4:1]);
                check_field("window_hit",      want.hit,      o_m_tdata[5]);
                check_field("window_start",    want.start,    o_m_tdata[16:6]);
                check_field("sequence_min",    want.smin,     o_m_tdata[21:17]);
                check_field("sequence_hit",    want.seq_hit,  o_m_tdata[22]);
                check_field("best_start",      want.best,     o_m_tdata[33:23]);
                check_field("padding",         0,             o_m_tdata[OUT_W-1:34]);
                check_field("sequence_done",   want.done,     o_m_tlast);
                if (want.hit)
                    n_window_hits++;
                if (want.seq_hit)
                    n_seq_hits++;
                if (want.start == SAT_START)
                    n_saturated++;
            end
            n_results++;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (i_s_tvalid && !o_s_tready)
            n_in_stalls++;
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // corner cases on reset settings and at the register extremes
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // reset settings, a run too short to fill the window
        send_symbol(8'h00, 1'b0);
        send_symbol(CHAR_T, 1'b0);
        send_symbol(CHAR_C, 1'b0);
        send_symbol(CHAR_G, 1'b1);
        drain();
        // all-G motif, widest limit: exact match, a tie, then one mismatch
        write_reg(REG_MOTIF_CODE, {MOTIF_W{1'b1}});
        write_reg(REG_MISMATCH_LIMIT, MOTIF_W'(15));
        for (int i = 0; i < WIN_LEN + 1; i++)
            send_symbol(CHAR_G, 1'b0);
        send_symbol(8'hFF, 1'b1);
        // single-symbol run
        send_symbol(CHAR_C, 1'b1);
        drain();
    endtask

    // random runs under one setting and one idling mode
    task automatic test_random_traffic(input logic [MOTIF_W-1:0] motif,
                                       input logic [MOTIF_W-1:0] limit_word,
                                       input int idle_pct, input int stall_pct,
                                       input int n_items);
        int start_count;
        int len;
        write_reg(REG_MOTIF_CODE, motif);
        write_reg(REG_MISMATCH_LIMIT, limit_word);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_count    = n_symbols;
        while (n_symbols - start_count < n_items) begin
            if ($urandom_range(99) < 10) begin
                // broken runs that never fill the window
                send_sequence($urandom_range(1, WIN_LEN - 1), 1'b0, 0);
            end else begin
                len = $urandom_range(WIN_LEN, 60);
                send_sequence(len, $urandom_range(99) < 70, $urandom_range(5, 25));
            end
        end
        drain();
    endtask

    // results held off long enough to back up the input side
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 400;
        send_sequence(60, 1'b1, 10);
        drain();
    endtask

    // one run past the position limit so the start saturates
    task automatic test_long_sequence();
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        write_reg(REG_MISMATCH_LIMIT, MOTIF_W'(4));
        send_sequence(SEQ_CAP + 16, 1'b1, 15);
        drain();
    endtask

    initial begin
        mdl_motif = '0;
        mdl_limit = LIMIT_RESET;
        clear_run_state();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(MOTIF_W'($urandom), MOTIF_W'(3), 0, 0, 220);
        test_random_traffic({MOTIF_W{1'b1}}, MOTIF_W'(15), 86, 0, 220);
        test_random_traffic(MOTIF_W'($urandom), MOTIF_W'(0), 0, 86, 220);
        test_random_traffic('0, {(MOTIF_W-LIMIT_W)'($urandom), LIMIT_W'($urandom)},
                            17, 17, 220);
        test_backpressure();
        test_long_sequence();

        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            mismatch_count++;
            $display("%0d expected results never arrived", expected_results.size());
        end

        $display("covered %0d symbols in %0d runs, %0d results checked",
                 n_symbols, n_sequences, n_results);
        $display("window hits %0d, run hits %0d, saturated starts %0d, input stalls %0d",
                 n_window_hits, n_seq_hits, n_saturated, n_in_stalls);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
